[src/vds_pkg.sv]
// Shared types and codes of the VOQ deficit scheduler.
`default_nettype none
package vds_pkg;

	localparam logic [1:0] REQ_ENQ  = 2'd0;
	localparam logic [1:0] REQ_TICK = 2'd1;
	localparam logic [1:0] REQ_WGT  = 2'd2;

	localparam logic [1:0] KIND_ENQ   = 2'd0;
	localparam logic [1:0] KIND_GRANT = 2'd1;
	localparam logic [1:0] KIND_ACK   = 2'd2;

	localparam logic [1:0] PRI_LOW  = 2'd0;
	localparam logic [1:0] PRI_MID  = 2'd1;
	localparam logic [1:0] PRI_HIGH = 2'd2;

	localparam int LIMIT_W     = 7;
	localparam int LIMIT_RESET = 64;

	typedef struct packed {
		logic [1:0] req_type;
		logic [2:0] in_port;
		logic [2:0] out_port;
		logic [1:0] pkt_priority;
		logic [7:0] pkt_size;
		logic [7:0] weight_value;
	} req_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic       status;
		logic       granted;
		logic [2:0] grant_output;
		logic [2:0] grant_input;
		logic [1:0] grant_priority;
		logic [7:0] grant_size;
		logic       last;
	} res_t;

	// downward rotation: high -> mid -> low -> high
	function automatic logic [1:0] pri_next(input logic [1:0] p);
		logic [1:0] r;
		case (p)
			PRI_LOW:  r = PRI_HIGH;
			PRI_MID:  r = PRI_LOW;
			PRI_HIGH: r = PRI_MID;
			default:  r = PRI_HIGH;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[src/vds_ram.sv]
// Simple dual-port RAM, one write and one registered read per cycle.
`default_nettype none
module vds_ram #(
	parameter int W = 8,
	parameter int D = 64
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[src/voq_deficit_scheduler.sv]
// VOQ deficit round robin scheduler: control sequencer and state memories.
//
// Enqueues and weight writes each pass through a request and pair row read,
// a modify/write and a result load; an enqueue or weight write to a port
// outside PORTS goes straight from the request to the result load. A tick
// first adds every weight to its deficit, one pair row per cycle through the
// pair memory port, then for each output with a pending input does a pending
// FIFO read, pair row read, packet size read, write back and grant beat, and
// for an output without one only the pending FIFO check and grant beat. A
// stalled result beat holds the sequence until it is taken.
// After reset a clearing pass initializes every row of the pair memory; no
// request is taken during it, configuration writes are.
// A result beat waits in an output register while the next request is taken.
`default_nettype none
module voq_deficit_scheduler #(
	parameter int PORTS     = 8,
	parameter int VOQ_DEPTH = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire vds_pkg::req_t                 req,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output vds_pkg::res_t                      res,
	input  wire logic                          cfg_we,
	input  wire logic [vds_pkg::LIMIT_W-1:0]   cfg_wdata
);
	import vds_pkg::*;

	localparam int NPAIR = PORTS * PORTS;
	localparam int PW    = $clog2(PORTS);
	localparam int PAW   = $clog2(NPAIR);
	localparam int PCW   = $clog2(PORTS + 1);
	localparam int HW    = $clog2(VOQ_DEPTH);
	localparam int CW    = $clog2(VOQ_DEPTH + 1);
	localparam int SD    = NPAIR * 3 * VOQ_DEPTH;
	localparam int SAW   = $clog2(SD);
	localparam int LW    = (CW > LIMIT_W) ? CW : LIMIT_W;

	typedef struct packed {
		logic [15:0]         deficit;
		logic [7:0]          weight;
		logic [1:0]          rot;
		logic [CW-1:0]       occ;
		logic [2:0][HW-1:0]  head;
		logic [2:0][CW-1:0]  cnt;
		logic                pflag;
	} row_t;

	localparam int RW = $bits(row_t);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_ENQ, S_EMIT, S_SWEEP,
		S_OPOP, S_OFIFO, S_OROW, S_OSIZE
	} state_t;

	function automatic logic [PAW-1:0] pair_of(input logic [PW-1:0] i,
			input logic [PW-1:0] o);
		return PAW'(PAW'(i) * PAW'(PORTS) + PAW'(o));
	endfunction

	function automatic logic [SAW-1:0] slot_addr(input logic [PAW-1:0] pr,
			input logic [1:0] p, input logic [HW-1:0] s);
		logic [SAW-1:0] q;
		q = SAW'(SAW'(pr) * SAW'(3) + SAW'(p));
		return SAW'(q * SAW'(VOQ_DEPTH) + SAW'(s));
	endfunction

	function automatic logic [HW-1:0] head_inc(input logic [HW-1:0] h);
		logic [HW:0] n;
		n = (HW+1)'(h) + (HW+1)'(1);
		return (n == (HW+1)'(VOQ_DEPTH)) ? HW'(0) : n[HW-1:0];
	endfunction

	function automatic res_t beat(input logic [1:0] kind, input logic st,
			input logic [2:0] go, input logic lst);
		res_t b;
		b              = '0;
		b.result_kind  = kind;
		b.status       = st;
		b.grant_output = go;
		b.last         = lst;
		return b;
	endfunction

	state_t                  state_q;
	req_t                    req_q;
	logic [PAW-1:0]          pair_q;
	logic [PAW:0]            cnt_q;
	logic [PW-1:0]           oc_q;
	logic [PW-1:0]           inp_q;
	row_t                    row_q;
	logic [1:0]              pri_q;
	logic                    found_q;
	res_t                    pend_q;
	res_t                    res_q;
	logic                    res_valid_q;
	logic [LIMIT_W-1:0]      blim_q;
	logic [PW-1:0]           phead_q [PORTS];
	logic [PCW-1:0]          pcnt_q  [PORTS];

	logic                    pm_we;
	logic [PAW-1:0]          pm_waddr, pm_raddr;
	logic [RW-1:0]           pm_wdata, pm_rdata;
	logic                    st_we;
	logic [SAW-1:0]          st_waddr, st_raddr;
	logic [7:0]              st_rdata;
	logic                    pf_we;
	logic [PAW-1:0]          pf_waddr, pf_raddr;
	logic [PW-1:0]           pf_wdata, pf_rdata;

	vds_ram #(.W(RW), .D(NPAIR)) u_pair_mem (
		.clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
		.raddr(pm_raddr), .rdata(pm_rdata)
	);
	vds_ram #(.W(8), .D(SD)) u_size_mem (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(req_q.pkt_size),
		.raddr(st_raddr), .rdata(st_rdata)
	);
	vds_ram #(.W(PW), .D(NPAIR)) u_pend_mem (
		.clk(clk), .we(pf_we), .waddr(pf_waddr), .wdata(pf_wdata),
		.raddr(pf_raddr), .rdata(pf_rdata)
	);

	logic            in_ok, q_ok, accept, emit;
	logic [PW-1:0]   in_i, in_o, q_i, q_o;
	logic [1:0]      q_pri;
	row_t            rd, row_reset, row_enq, row_swp, row_srv;
	res_t            pend_srv;
	logic [LW-1:0]   lim;
	logic            full, enq_push, srv, srv_push;
	logic [HW:0]     tail;
	logic [PW:0]     ptail;
	logic [1:0]      p0, p1, p2, pri_sel;
	logic            f0, f1, f2;
	logic [16:0]     dsum;

	assign accept = req_valid && req_ready;
	assign emit   = (state_q == S_EMIT) && (!res_valid_q || res_ready);
	assign in_i   = PW'(req.in_port);
	assign in_o   = PW'(req.out_port);
	assign in_ok  = (5'(req.in_port) < 5'(PORTS)) && (5'(req.out_port) < 5'(PORTS));
	assign q_i    = PW'(req_q.in_port);
	assign q_o    = PW'(req_q.out_port);
	assign q_ok   = (5'(req_q.in_port) < 5'(PORTS)) && (5'(req_q.out_port) < 5'(PORTS));
	assign q_pri  = (req_q.pkt_priority == 2'd3) ? PRI_HIGH : req_q.pkt_priority;
	assign rd     = row_t'(pm_rdata);
	assign lim    = (LW'(blim_q) > LW'(VOQ_DEPTH)) ? LW'(VOQ_DEPTH) : LW'(blim_q);
	assign full   = LW'(rd.occ) >= lim;
	assign tail   = ((HW+1)'(rd.head[q_pri]) + (HW+1)'(rd.cnt[q_pri]) >= (HW+1)'(VOQ_DEPTH))
		? (HW+1)'(rd.head[q_pri]) + (HW+1)'(rd.cnt[q_pri]) - (HW+1)'(VOQ_DEPTH)
		: (HW+1)'(rd.head[q_pri]) + (HW+1)'(rd.cnt[q_pri]);
	assign enq_push = !rd.pflag && (pcnt_q[q_o] < PCW'(PORTS));

	always_comb begin
		row_reset         = '0;
		row_reset.weight  = 8'd1;
		row_reset.rot     = PRI_HIGH;

		row_enq = rd;
		if (req_q.req_type == REQ_WGT) begin
			row_enq.weight = req_q.weight_value;
		end else begin
			row_enq.cnt[q_pri] = rd.cnt[q_pri] + CW'(1);
			row_enq.occ        = rd.occ + CW'(1);
			if (enq_push) begin
				row_enq.pflag = 1'b1;
			end
		end

		dsum    = 17'(rd.deficit) + 17'(rd.weight);
		row_swp = rd;
		row_swp.deficit = dsum[16] ? 16'hffff : dsum[15:0];

		p0      = (rd.rot == 2'd3) ? PRI_LOW : rd.rot;
		p1      = pri_next(p0);
		p2      = pri_next(p1);
		f0      = rd.cnt[p0] != '0;
		f1      = rd.cnt[p1] != '0;
		f2      = rd.cnt[p2] != '0;
		pri_sel = f0 ? p0 : (f1 ? p1 : p2);

		srv     = found_q && (row_q.deficit >= 16'(st_rdata));
		row_srv = row_q;
		if (srv) begin
			row_srv.deficit     = row_q.deficit - 16'(st_rdata);
			row_srv.head[pri_q] = head_inc(row_q.head[pri_q]);
			row_srv.cnt[pri_q]  = row_q.cnt[pri_q] - CW'(1);
			row_srv.occ         = row_q.occ - CW'(1);
			row_srv.rot         = pri_next(pri_q);
		end
		srv_push = row_srv.occ != '0;
		row_srv.pflag = srv_push;

		pend_srv                = pend_q;
		pend_srv.granted        = 1'b1;
		pend_srv.grant_input    = 3'(inp_q);
		pend_srv.grant_priority = pri_q;
		pend_srv.grant_size     = st_rdata;
	end

	always_comb begin
		ptail = (PW+1)'(phead_q[(state_q == S_OSIZE) ? oc_q : q_o])
			+ (PW+1)'(pcnt_q[(state_q == S_OSIZE) ? oc_q : q_o]);
		if (ptail >= (PW+1)'(PORTS)) begin
			ptail = ptail - (PW+1)'(PORTS);
		end

		pm_we    = 1'b0;
		pm_waddr = pair_q;
		pm_wdata = RW'(row_enq);
		pm_raddr = pair_of(in_i, in_o);
		st_we    = 1'b0;
		st_waddr = slot_addr(pair_q, q_pri, tail[HW-1:0]);
		st_raddr = slot_addr(pair_q, pri_sel, rd.head[pri_sel]);
		pf_we    = 1'b0;
		pf_waddr = pair_of(q_o, ptail[PW-1:0]);
		pf_wdata = q_i;
		pf_raddr = pair_of(oc_q, phead_q[oc_q]);

		case (state_q)
			S_CLEAR: begin
				pm_we    = 1'b1;
				pm_waddr = cnt_q[PAW-1:0];
				pm_wdata = RW'(row_reset);
			end
			S_IDLE: begin
				if (req.req_type == REQ_TICK) begin
					pm_raddr = '0;
				end
			end
			S_ENQ: begin
				if (req_q.req_type == REQ_WGT || !full) begin
					pm_we = 1'b1;
				end
				if (req_q.req_type == REQ_ENQ && !full) begin
					st_we = 1'b1;
					pf_we = enq_push;
				end
			end
			S_SWEEP: begin
				pm_we    = 1'b1;
				pm_waddr = PAW'(cnt_q - (PAW+1)'(1));
				pm_wdata = RW'(row_swp);
				pm_raddr = cnt_q[PAW-1:0];
			end
			S_OFIFO: begin
				pm_raddr = pair_of(pf_rdata, oc_q);
			end
			S_OSIZE: begin
				pm_we    = 1'b1;
				pm_wdata = RW'(row_srv);
				pf_we    = srv_push;
				pf_waddr = pair_of(oc_q, ptail[PW-1:0]);
				pf_wdata = inp_q;
			end
			default: begin
			end
		endcase
	end

	assign req_ready = state_q == S_IDLE;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			oc_q        <= '0;
			res_valid_q <= 1'b0;
			blim_q      <= LIMIT_W'(LIMIT_RESET);
			for (int k = 0; k < PORTS; k++) begin
				phead_q[k] <= '0;
				pcnt_q[k]  <= '0;
			end
		end else begin
			if (cfg_we) begin
				blim_q <= cfg_wdata;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + (PAW+1)'(1);
					if (cnt_q == (PAW+1)'(NPAIR - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						req_q  <= req;
						pair_q <= pair_of(in_i, in_o);
						case (req.req_type)
							REQ_ENQ: begin
								if (in_ok) begin
									state_q <= S_ENQ;
								end else begin
									pend_q  <= beat(KIND_ENQ, 1'b1, 3'd0, 1'b1);
									state_q <= S_EMIT;
								end
							end
							REQ_TICK: begin
								cnt_q   <= (PAW+1)'(1);
								state_q <= S_SWEEP;
							end
							REQ_WGT: begin
								pend_q  <= beat(KIND_ACK, 1'b0, 3'd0, 1'b1);
								state_q <= in_ok ? S_ENQ : S_EMIT;
							end
							default: begin
							end
						endcase
					end
				end
				S_ENQ: begin
					if (req_q.req_type == REQ_ENQ) begin
						pend_q <= beat(KIND_ENQ, full, 3'd0, 1'b1);
						if (!full && enq_push) begin
							pcnt_q[q_o] <= pcnt_q[q_o] + PCW'(1);
						end
					end
					state_q <= S_EMIT;
				end
				S_SWEEP: begin
					if (cnt_q == (PAW+1)'(NPAIR)) begin
						oc_q    <= '0;
						state_q <= S_OPOP;
					end else begin
						cnt_q <= cnt_q + (PAW+1)'(1);
					end
				end
				S_OPOP: begin
					pend_q <= beat(KIND_GRANT, 1'b0, 3'(oc_q), oc_q == PW'(PORTS - 1));
					if (pcnt_q[oc_q] == '0) begin
						state_q <= S_EMIT;
					end else begin
						phead_q[oc_q] <= (phead_q[oc_q] == PW'(PORTS - 1))
							? PW'(0) : phead_q[oc_q] + PW'(1);
						pcnt_q[oc_q]  <= pcnt_q[oc_q] - PCW'(1);
						state_q       <= S_OFIFO;
					end
				end
				S_OFIFO: begin
					inp_q   <= pf_rdata;
					pair_q  <= pair_of(pf_rdata, oc_q);
					state_q <= S_OROW;
				end
				S_OROW: begin
					row_q       <= rd;
					pri_q       <= pri_sel;
					found_q     <= f0 || f1 || f2;
					state_q     <= S_OSIZE;
				end
				S_OSIZE: begin
					if (srv) begin
						pend_q <= pend_srv;
					end
					if (srv_push) begin
						pcnt_q[oc_q] <= pcnt_q[oc_q] + PCW'(1);
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit) begin
						res_q <= pend_q;
						if (req_q.req_type == REQ_TICK && oc_q != PW'(PORTS - 1)) begin
							oc_q    <= oc_q + PW'(1);
							state_q <= S_OPOP;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_pcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pcnt_q[oc_q] <= PCW'(PORTS))
		else $error("pending count above port count");
	a_tick_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.req_type == REQ_TICK) |=> (state_q == S_SWEEP))
		else $error("tick did not start deficit sweep");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_ready) |=> (res_valid_q && $stable(res_q)))
		else $error("result beat changed while stalled");
	a_emit_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && pend_q.result_kind != KIND_GRANT) |-> pend_q.last)
		else $error("single result beat without last");

endmodule
`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for the VOQ deficit round robin scheduler.
`timescale 1ns / 100ps
module testbench;
	import vds_pkg::*;

	localparam int NP = 8;
	localparam int DEPTH = 64;
	localparam int SETTLE = 200;
	localparam int CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;
	logic cfg_we = 1'b0;
	logic [LIMIT_W-1:0] cfg_wdata = '0;

	voq_deficit_scheduler uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// scheduler mirror
	logic [7:0] pkt_store [NP*NP*3][DEPTH];
	int q_head [NP*NP*3];
	int q_cnt [NP*NP*3];
	int pair_occ [NP*NP];
	int deficit_ctr [NP*NP];
	logic [7:0] quantum [NP*NP];
	logic [1:0] rr_pri [NP*NP];
	logic [2:0] wait_fifo [NP][NP];
	int wait_head [NP];
	int wait_cnt [NP];
	bit wait_flag [NP*NP];
	int limit_reg;

	res_t grants_due [$];
	int errors = 0;
	int beats_checked = 0;
	int grants_seen = 0;
	int drops_seen = 0;
	int cycles = 0;
	bit send_gaps = 1'b0;
	bit recv_gaps = 1'b0;
	int hold_cycles = 0;

	task automatic mirror_reset();
		for (int p = 0; p < NP*NP; p++) begin
			pair_occ[p] = 0;
			deficit_ctr[p] = 0;
			quantum[p] = 8'd1;
			rr_pri[p] = PRI_HIGH;
			wait_flag[p] = 0;
			for (int k = 0; k < 3; k++) begin
				q_head[p*3+k] = 0;
				q_cnt[p*3+k] = 0;
			end
		end
		for (int o = 0; o < NP; o++) begin
			wait_head[o] = 0;
			wait_cnt[o] = 0;
		end
		limit_reg = LIMIT_RESET;
	endtask

	task automatic wait_list_push(input int o, input int i);
		if (!wait_flag[i*NP+o] && wait_cnt[o] < NP) begin
			wait_fifo[o][(wait_head[o] + wait_cnt[o]) % NP] = i[2:0];
			wait_cnt[o]++;
			wait_flag[i*NP+o] = 1;
		end
	endtask

	task automatic sched_predict(input req_t r);
		res_t e;
		int i, o, pri, pair, q, lim, sum, tries;
		i = r.in_port;
		o = r.out_port;
		pair = i*NP + o;
		e = '0;
		e.last = 1'b1;
		if (r.req_type == REQ_ENQ) begin
			e.result_kind = KIND_ENQ;
			pri = (r.pkt_priority > PRI_HIGH) ? PRI_HIGH : r.pkt_priority;
			lim = (limit_reg > DEPTH) ? DEPTH : limit_reg;
			if (pair_occ[pair] >= lim) begin
				e.status = 1'b1;
			end else begin
				q = pair*3 + pri;
				pkt_store[q][(q_head[q] + q_cnt[q]) % DEPTH] = r.pkt_size;
				q_cnt[q]++;
				pair_occ[pair]++;
				wait_list_push(o, i);
			end
			grants_due.push_back(e);
		end else if (r.req_type == REQ_WGT) begin
			e.result_kind = KIND_ACK;
			quantum[pair] = r.weight_value;
			grants_due.push_back(e);
		end else if (r.req_type == REQ_TICK) begin
			for (int p = 0; p < NP*NP; p++) begin
				sum = deficit_ctr[p] + quantum[p];
				deficit_ctr[p] = (sum > 65535) ? 65535 : sum;
			end
			for (int oo = 0; oo < NP; oo++) begin
				e = '0;
				e.result_kind = KIND_GRANT;
				e.grant_output = oo[2:0];
				e.last = (oo == NP-1);
				if (wait_cnt[oo] > 0) begin
					i = wait_fifo[oo][wait_head[oo]];
					pair = i*NP + oo;
					pri = rr_pri[pair] % 3;
					tries = 0;
					wait_head[oo] = (wait_head[oo] + 1) % NP;
					wait_cnt[oo]--;
					wait_flag[pair] = 0;
					while (q_cnt[pair*3+pri] == 0 && tries < 3) begin
						pri = (pri + 2) % 3;
						tries++;
					end
					if (tries < 3) begin
						q = pair*3 + pri;
						if (deficit_ctr[pair] >= pkt_store[q][q_head[q]]) begin
							e.granted = 1'b1;
							e.grant_input = i[2:0];
							e.grant_priority = pri[1:0];
							e.grant_size = pkt_store[q][q_head[q]];
							deficit_ctr[pair] -= pkt_store[q][q_head[q]];
							q_head[q] = (q_head[q] + 1) % DEPTH;
							q_cnt[q]--;
							pair_occ[pair]--;
							rr_pri[pair] = (pri + 2) % 3;
						end
					end
					if (pair_occ[pair] > 0)
						wait_list_push(oo, i);
				end
				grants_due.push_back(e);
			end
		end
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still due", $time, grants_due.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (res_valid && res_ready) begin
			beats_checked++;
			if (grants_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, actual %p", $time, res);
			end else begin
				if (res !== grants_due[0]) begin
					errors++;
					$display("%0t: mismatch expected %p actual %p", $time, grants_due[0], res);
				end
				if (res.granted === 1'b1)
					grants_seen++;
				if (res.status === 1'b1)
					drops_seen++;
				void'(grants_due.pop_front());
			end
		end
	end

	// result side flow control
	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				res_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else if (recv_gaps && $urandom_range(0, 7) == 0) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			res_ready <= 1'b1;
		end
	end

	task automatic send_req(input req_t r);
		if (send_gaps && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		sched_predict(r);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (grants_due.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_limit(input int v);
		drain();
		cfg_wdata <= v[LIMIT_W-1:0];
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_reg = v & 127;
	endtask

	function automatic req_t mk(input logic [1:0] t, input int i, input int o,
			input int p, input int s, input int w);
		req_t r;
		r.req_type = t;
		r.in_port = i[2:0];
		r.out_port = o[2:0];
		r.pkt_priority = p[1:0];
		r.pkt_size = s[7:0];
		r.weight_value = w[7:0];
		return r;
	endfunction

	function automatic req_t rand_req(input int port_span);
		int sel;
		logic [1:0] t;
		sel = $urandom_range(0, 99);
		if (sel < 55) t = REQ_ENQ;
		else if (sel < 80) t = REQ_TICK;
		else if (sel < 96) t = REQ_WGT;
		else t = 2'd3;
		return mk(t, $urandom_range(0, port_span), $urandom_range(0, port_span),
			$urandom_range(0, 3), ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
			: $urandom_range(1, 40), $urandom_range(0, 255));
	endfunction

	task automatic test_directed();
		send_req(mk(REQ_WGT, 0, 0, 0, 0, 255));
		send_req(mk(REQ_WGT, 7, 7, 3, 255, 0));
		send_req(mk(REQ_ENQ, 0, 0, PRI_LOW, 1, 0));
		send_req(mk(REQ_ENQ, 0, 0, PRI_MID, 255, 255));
		send_req(mk(REQ_ENQ, 0, 0, 3, 0, 0));
		send_req(mk(REQ_ENQ, 7, 7, PRI_HIGH, 255, 0));
		send_req(mk(2'd3, 5, 5, 1, 9, 9));
		send_req(mk(REQ_TICK, 0, 0, 0, 0, 0));
		send_req(mk(REQ_TICK, 7, 7, 3, 255, 255));
		send_req(mk(REQ_ENQ, 3, 4, PRI_HIGH, 2, 0));
		send_req(mk(REQ_TICK, 0, 0, 0, 0, 0));
		send_req(mk(REQ_TICK, 0, 0, 0, 0, 0));
		send_req(mk(REQ_WGT, 7, 7, 0, 0, 255));
		send_req(mk(REQ_TICK, 0, 0, 0, 0, 0));
		set_limit(1);
		send_req(mk(REQ_ENQ, 2, 6, PRI_LOW, 5, 0));
		send_req(mk(REQ_ENQ, 2, 6, PRI_HIGH, 5, 0));
		send_req(mk(REQ_TICK, 0, 0, 0, 0, 0));
		set_limit(0);
		send_req(mk(REQ_ENQ, 1, 1, PRI_LOW, 3, 0));
		set_limit(127);
		send_req(mk(REQ_ENQ, 1, 1, PRI_MID, 3, 0));
		send_req(mk(REQ_TICK, 0, 0, 0, 0, 0));
	endtask

	task automatic test_buffer_full();
		set_limit(64);
		for (int n = 0; n < 66; n++)
			send_req(mk(REQ_ENQ, 4, 2, $urandom_range(0, 3), $urandom_range(0, 3), 0));
		send_req(mk(REQ_WGT, 4, 2, 0, 0, 255));
		for (int n = 0; n < 6; n++)
			send_req(mk(REQ_TICK, 0, 0, 0, 0, 0));
	endtask

	task automatic test_saturation();
		send_req(mk(REQ_WGT, 6, 3, 0, 0, 255));
		for (int n = 0; n < 260; n++)
			send_req(mk(REQ_TICK, 0, 0, 0, 0, 0));
		send_req(mk(REQ_ENQ, 6, 3, PRI_LOW, 255, 0));
		send_req(mk(REQ_TICK, 0, 0, 0, 0, 0));
	endtask

	task automatic test_random(input int count, input int port_span);
		for (int n = 0; n < count; n++)
			send_req(rand_req(port_span));
	endtask

	task automatic test_backpressure();
		hold_cycles = 600;
		for (int n = 0; n < 20; n++)
			send_req(rand_req(7));
		drain();
		for (int n = 0; n < 10; n++)
			send_req(rand_req(3));
	endtask

	initial begin
		mirror_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		test_buffer_full();
		test_saturation();
		set_limit(3);
		test_random(25, 1);
		set_limit($urandom_range(1, 126));
		test_random(25, 7);
		set_limit(64);
		test_random(25, 3);
		test_backpressure();
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		set_limit(2);
		test_random(25, 7);
		drain();
		$display("Checked %0d result beats: %0d grants, %0d drops.",
			beats_checked, grants_seen, drops_seen);
		$display("Covered weights, priorities, buffer limits, saturation and stalls.");
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
